@@ rtl/wpms_pkg.sv @@
// Shared constants and types for the word piece minimum segmentation core.
`default_nettype none
package wpms_pkg;

  localparam int MAX_PIECES    = 128;
  localparam int MAX_PIECE_LEN = 5;
  localparam int MAX_TEXT_LEN  = 32768;

  localparam int DICT_AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CNT_W   = $clog2(MAX_PIECES + 1);
  localparam int LEN_W   = 3;
  localparam int HIST_W  = 8 * MAX_PIECE_LEN;
  localparam int POS_W   = 16;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] UNREACH   = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_TOP = 16'hFFFE;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_TEXT  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HIST_W-1:0] bytes;
  } entry_t;

  typedef logic [MAX_PIECE_LEN-1:0][COUNT_W-1:0] counts_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] cand;
  } match_t;

endpackage
`default_nettype wire

@@ rtl/wpms_dict_ram.sv @@
// Single-port-write, registered-read RAM holding the dictionary pieces.
`default_nettype none
module wpms_dict_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 43
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/wpms_match.sv @@
// Suffix compare of one dictionary entry and candidate count computation.
`default_nettype none
module wpms_match (
  input  wpms_pkg::entry_t                entry,
  input  logic [wpms_pkg::HIST_W-1:0]     hist,
  input  wpms_pkg::counts_t               counts,
  input  logic [wpms_pkg::POS_W-1:0]      pos,
  output wpms_pkg::match_t                result
);
  import wpms_pkg::*;

  logic               sat;
  logic               len_ok;
  logic               bytes_eq;
  logic               skip;
  logic               at_start;
  logic [COUNT_W-1:0] base;
  logic [POS_W-1:0]   km1;

  always_comb begin
    sat      = (pos >= POS_W'(MAX_TEXT_LEN));
    len_ok   = 1'b0;
    bytes_eq = 1'b0;
    base     = UNREACH;
    for (int kk = 1; kk <= MAX_PIECE_LEN; kk++) begin
      if (entry.len == LEN_W'(kk)) begin
        len_ok   = 1'b1;
        base     = counts[kk-1];
        bytes_eq = 1'b1;
        for (int j = 0; j < kk; j++) begin
          if (entry.bytes[8*j +: 8] != hist[8*(kk-1-j) +: 8]) begin
            bytes_eq = 1'b0;
          end
        end
      end
    end
    km1      = POS_W'(entry.len) - POS_W'(1);
    at_start = !sat && (km1 == pos);
    skip     = !sat && (km1 > pos);
    if (at_start) begin
      base = '0;
    end
    result.hit  = len_ok && !skip && (base != UNREACH) && bytes_eq;
    result.cand = (base >= COUNT_TOP) ? COUNT_TOP : base + COUNT_W'(1);
  end

endmodule
`default_nettype wire

@@ rtl/word_piece_min_segmentation_core.sv @@
// Top level: dictionary load/clear, per-byte dictionary scan, result register.
//
//  channel | signals                                          | item
//  --------+--------------------------------------------------+------------------------
//  in      | in_valid in_ready op piece_bytes piece_len       | command or target byte
//          | text_byte text_last                              |
//  out     | out_valid out_ready min_pieces reachable         | final count per target
//
// Clear, add and unknown ops complete on acceptance; the core stays idle. A target
// byte passes through the accept, one dictionary RAM read per stored piece, the
// registered read of the RAM, a step to close the scan, then the state update. The
// scan of the dictionary RAM grows with dict_count. Reset is synchronous and needs
// no clearing pass. A final byte waits in S_FINISH only while the previous result
// is still held in the output register.
`default_nettype none
module word_piece_min_segmentation_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [wpms_pkg::HIST_W-1:0]   piece_bytes,
  input  logic [wpms_pkg::LEN_W-1:0]    piece_len,
  input  logic [7:0]                    text_byte,
  input  logic                          text_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wpms_pkg::COUNT_W-1:0]  min_pieces,
  output logic                          reachable
);
  import wpms_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t              state;
  logic [CNT_W-1:0]    dict_count;
  logic [HIST_W-1:0]   recent_bytes;
  counts_t             recent_counts;
  logic [POS_W-1:0]    text_pos;
  logic [CNT_W-1:0]    scan_addr;
  logic                rd_pend;
  logic [HIST_W-1:0]   cur_hist;
  logic                cur_last;
  logic [COUNT_W-1:0]  best;

  logic                accept;
  logic                add_ok;
  logic                ram_we;
  entry_t              ram_wdata;
  entry_t              ram_rdata;
  match_t              hit_info;
  logic                out_free;
  logic                out_load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = (state == S_FINISH) && cur_last && out_free;
  assign add_ok   = (dict_count < CNT_W'(MAX_PIECES)) && (piece_len >= LEN_W'(1))
                    && (piece_len <= LEN_W'(MAX_PIECE_LEN));
  assign ram_we   = accept && (op == OP_ADD) && add_ok;
  assign ram_wdata.len   = piece_len;
  assign ram_wdata.bytes = piece_bytes;

  wpms_dict_ram #(
    .DEPTH(MAX_PIECES),
    .WIDTH($bits(entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dict_count[DICT_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (scan_addr[DICT_AW-1:0]),
    .rdata (ram_rdata)
  );

  wpms_match u_match (
    .entry  (ram_rdata),
    .hist   (cur_hist),
    .counts (recent_counts),
    .pos    (text_pos),
    .result (hit_info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dict_count    <= '0;
      recent_bytes  <= '0;
      recent_counts <= {MAX_PIECE_LEN{UNREACH}};
      text_pos      <= '0;
      scan_addr     <= '0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_CLEAR: dict_count <= '0;
              OP_ADD: begin
                if (add_ok) begin
                  dict_count <= dict_count + CNT_W'(1);
                end
              end
              OP_TEXT: begin
                cur_hist  <= {recent_bytes[HIST_W-9:0], text_byte};
                cur_last  <= text_last;
                best      <= UNREACH;
                scan_addr <= '0;
                rd_pend   <= 1'b0;
                state     <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_addr < dict_count) begin
            scan_addr <= scan_addr + CNT_W'(1);
            rd_pend   <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && hit_info.hit && (hit_info.cand < best)) begin
            best <= hit_info.cand;
          end
          if (!(scan_addr < dict_count) && !rd_pend) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cur_last) begin
            if (out_free) begin
              min_pieces    <= (best == UNREACH) ? '0 : best;
              reachable     <= (best != UNREACH);
              recent_bytes  <= '0;
              recent_counts <= {MAX_PIECE_LEN{UNREACH}};
              text_pos      <= '0;
              state         <= S_IDLE;
            end
          end else begin
            recent_bytes <= cur_hist;
            for (int i = MAX_PIECE_LEN - 1; i > 0; i--) begin
              recent_counts[i] <= recent_counts[i-1];
            end
            recent_counts[0] <= best;
            if (text_pos < POS_W'(MAX_TEXT_LEN)) begin
              text_pos <= text_pos + POS_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_dict_bound: assert property (@(posedge clk) disable iff (rst)
    dict_count <= CNT_W'(MAX_PIECES))
    else $error("dictionary count beyond capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    text_pos <= POS_W'(MAX_TEXT_LEN))
    else $error("text position beyond saturation");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == S_SCAN)
    else $error("pending dictionary read outside scan");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reachable) |-> min_pieces == '0)
    else $error("unreachable result with nonzero count");

  a_reach_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reachable) |-> min_pieces != '0)
    else $error("reachable result with zero count");

endmodule
`default_nettype wire
